// ===== sv/lrfs_pkg.sv =====
package lrfs_pkg;

    // Command codes of an input item
    typedef enum logic [1:0] {
        CMD_BEGIN  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_COMMIT = 2'd2,
        CMD_UPDATE = 2'd3
    } t_cmd;

    // Configuration register indexes
    localparam logic [7:0] CFG_LINE_LIMIT       = 8'd0;
    localparam logic [7:0] CFG_PROTOCOL_VERSION = 8'd1;

    // Configuration reset values
    localparam logic [7:0] LINE_LIMIT_RST       = 8'd64;
    localparam logic [7:0] PROTOCOL_VERSION_RST = 8'd1;

    // Result kinds
    localparam logic KIND_STATUS   = 1'b0;
    localparam logic KIND_FRAGMENT = 1'b1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] line_byte;
        logic       link_accept;
    } t_in_item;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] line_byte;
        logic       link_accept;
    } t_op;

    typedef struct packed {
        logic [7:0] index;
        logic [7:0] data;
    } t_cfg_req;

    typedef struct packed {
        logic [7:0] line_limit;
        logic [7:0] protocol_version;
    } t_cfg_regs;

    typedef struct packed {
        logic        kind;
        logic [7:0]  version;
        logic [7:0]  message_id;
        logic [7:0]  fragment_index;
        logic [7:0]  fragment_count;
        logic [5:0]  payload_length;
        logic [7:0]  payload_byte;
        logic        last;
        logic        busy_res;
        logic [31:0] sent_lines;
        logic [31:0] dropped_lines;
        logic [7:0]  ring_peak;
    } t_res;

endpackage

// ===== sv/lrfs_chan_if.sv =====
interface lrfs_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/line_ring_fragmenting_sender.sv =====
// A request passes a four-deep queue and reaches the back end the cycle after it is taken;
// begin, add, commit and an idle update give one status result in the next cycle, one per
// cycle while the output is free. An update that starts a line holds the back end through:
// accept, read the length slot, count fragments, size the fragment, then one byte per cycle
// while the output is free. An update that continues a line skips the length read and count.
// Synchronous active-low reset clears control state and counters, sets line_limit to 64 and
// protocol_version to 1, and leaves the ring memory contents as they are.
module line_ring_fragmenting_sender #(
    parameter int RING_DEPTH    = 128,
    parameter int PAYLOAD_BYTES = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lrfs_chan_if.sink   i_item,
    lrfs_chan_if.sink   i_cfg,
    lrfs_chan_if.source o_res
);

    lrfs_pkg::t_cfg_regs r_cfg;

    lrfs_chan_if #(.t_payload(lrfs_pkg::t_op)) q_ch ();

    // Write configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_limit       <= lrfs_pkg::LINE_LIMIT_RST;
            r_cfg.protocol_version <= lrfs_pkg::PROTOCOL_VERSION_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.payload.index)
                lrfs_pkg::CFG_LINE_LIMIT:       r_cfg.line_limit       <= i_cfg.payload.data;
                lrfs_pkg::CFG_PROTOCOL_VERSION: r_cfg.protocol_version <= i_cfg.payload.data;
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    lrfs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_item),
        .o_q     (q_ch.source)
    );

    lrfs_back #(
        .RING_DEPTH    (RING_DEPTH),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_regs (r_cfg),
        .i_q        (q_ch.sink),
        .o_res      (o_res)
    );

endmodule

// ===== sv/lrfs_front.sv =====
module lrfs_front (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lrfs_chan_if.sink   i_in,
    lrfs_chan_if.source o_q
);

    localparam int QP_W = $clog2(lrfs_pkg::QUEUE_DEPTH);
    localparam int QC_W = $clog2(lrfs_pkg::QUEUE_DEPTH + 1);

    lrfs_pkg::t_op   r_queue [lrfs_pkg::QUEUE_DEPTH];
    logic [QP_W-1:0] r_wr_ptr;
    logic [QP_W-1:0] r_rd_ptr;
    logic [QC_W-1:0] r_count;
    logic            push;
    logic            pop;
    lrfs_pkg::t_op   op;

    // Classify the incoming request into a queued operation
    always_comb begin
        op.cmd         = lrfs_pkg::t_cmd'(i_in.payload.cmd);
        op.line_byte   = i_in.payload.line_byte;
        op.link_accept = i_in.payload.link_accept;
    end

    assign i_in.ready = (r_count != QC_W'(lrfs_pkg::QUEUE_DEPTH));
    assign o_q.valid  = (r_count != '0);
    assign o_q.payload = r_queue[r_rd_ptr];

    assign push = i_in.valid && i_in.ready;
    assign pop  = o_q.valid && o_q.ready;

    // Advance the queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QP_W'(lrfs_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QP_W'(lrfs_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Hold queued operations
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= op;
        end
    end

endmodule

// ===== sv/lrfs_back.sv =====
module lrfs_back #(
    parameter int RING_DEPTH    = 128,
    parameter int PAYLOAD_BYTES = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lrfs_pkg::t_cfg_regs i_cfg_regs,
    lrfs_chan_if.sink           i_q,
    lrfs_chan_if.source         o_res
);

    localparam int IDX_W   = $clog2(RING_DEPTH);
    localparam int CNT_W   = $clog2(PAYLOAD_BYTES + 1);
    localparam int SH      = 16;
    localparam int RECIP   = ((1 << SH) + PAYLOAD_BYTES - 1) / PAYLOAD_BYTES;
    localparam int X_W     = 9;
    localparam int PROD_W  = X_W + SH + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_TOT,
        S_FRAG,
        S_EMIT
    } t_state;

    // Ring memory
    logic [7:0]       ring_mem [RING_DEPTH];
    logic [7:0]       rd_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]       wr_data;

    // Control state
    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_write_idx, n_write_idx;
    logic [IDX_W-1:0]  r_length_slot, n_length_slot;
    logic [7:0]        r_pending, n_pending;
    logic              r_line_open, n_line_open;
    logic              r_overflow, n_overflow;
    logic [IDX_W-1:0]  r_read_idx, n_read_idx;
    logic [7:0]        r_committed, n_committed;
    logic              r_sending, n_sending;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic [IDX_W-1:0]  r_end_idx, n_end_idx;
    logic [7:0]        r_cur_len, n_cur_len;
    logic [X_W-1:0]    r_offset, n_offset;
    logic [7:0]        r_cur_frag, n_cur_frag;
    logic [7:0]        r_total, n_total;
    logic [7:0]        r_cur_id, n_cur_id;
    logic [31:0]       r_sent, n_sent;
    logic [31:0]       r_dropped, n_dropped;
    logic [7:0]        r_peak, n_peak;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;

    // Payload registers
    lrfs_pkg::t_res    r_out, n_out;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [5:0]        r_len, n_len;
    logic [7:0]        r_fi, n_fi;
    logic [7:0]        r_fc, n_fc;
    logic              r_accept, n_accept;

    // Working values
    lrfs_pkg::t_op     op;
    logic              out_free;
    logic              out_load;
    logic              do_status;
    logic [IDX_W-1:0]  data_idx;
    logic [8:0]        end_sum;
    logic [X_W-1:0]    frag_x;
    logic [X_W-1:0]    remain;
    logic [7:0]        id_inc;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign op       = i_q.payload;
    assign out_free = !r_out_valid || o_res.ready;

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    // Execute one operation or one step of a fragment
    always_comb begin
        n_state       = r_state;
        n_write_idx   = r_write_idx;
        n_length_slot = r_length_slot;
        n_pending     = r_pending;
        n_line_open   = r_line_open;
        n_overflow    = r_overflow;
        n_read_idx    = r_read_idx;
        n_committed   = r_committed;
        n_sending     = r_sending;
        n_pos         = r_pos;
        n_end_idx     = r_end_idx;
        n_cur_len     = r_cur_len;
        n_offset      = r_offset;
        n_cur_frag    = r_cur_frag;
        n_total       = r_total;
        n_cur_id      = r_cur_id;
        n_sent        = r_sent;
        n_dropped     = r_dropped;
        n_peak        = r_peak;
        n_cnt         = r_cnt;
        n_out         = r_out;
        n_prod        = r_prod;
        n_len         = r_len;
        n_fi          = r_fi;
        n_fc          = r_fc;
        n_accept      = r_accept;

        i_q.ready = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = r_read_idx;
        wr_en     = 1'b0;
        wr_addr   = r_write_idx;
        wr_data   = op.line_byte;
        out_load  = 1'b0;
        do_status = 1'b0;

        data_idx = ring_next(r_read_idx);
        end_sum  = 9'(data_idx) + 9'(rd_data);
        frag_x   = X_W'(rd_data) + X_W'(PAYLOAD_BYTES - 1);
        remain   = X_W'(r_cur_len) - r_offset;
        id_inc   = r_cur_id + 8'd1;

        case (r_state)
            S_IDLE: begin
                if (i_q.valid && out_free) begin
                    i_q.ready = 1'b1;
                    n_accept  = op.link_accept;
                    case (op.cmd)
                        lrfs_pkg::CMD_BEGIN: begin
                            // Roll back an open line, then open a new one
                            if (r_line_open) begin
                                if (r_pending != 8'd0) begin
                                    n_write_idx = r_length_slot;
                                end
                                n_dropped = r_dropped + 32'd1;
                            end
                            n_line_open = 1'b1;
                            n_overflow  = 1'b0;
                            n_pending   = 8'd0;
                            if (9'(r_committed) >= 9'(RING_DEPTH)) begin
                                n_overflow = 1'b1;
                            end else begin
                                n_length_slot = n_write_idx;
                                n_write_idx   = ring_next(n_write_idx);
                                n_pending     = 8'd1;
                            end
                            do_status = 1'b1;
                        end
                        lrfs_pkg::CMD_ADD: begin
                            // Append a byte or mark the line overflowed
                            if (r_line_open && !r_overflow) begin
                                if ((r_pending == 8'd0) ||
                                    (r_pending > i_cfg_regs.line_limit) ||
                                    ((9'(r_committed) + 9'(r_pending)) >= 9'(RING_DEPTH))) begin
                                    n_overflow = 1'b1;
                                end else begin
                                    wr_en       = 1'b1;
                                    wr_addr     = r_write_idx;
                                    wr_data     = op.line_byte;
                                    n_write_idx = ring_next(r_write_idx);
                                    n_pending   = r_pending + 8'd1;
                                end
                            end
                            do_status = 1'b1;
                        end
                        lrfs_pkg::CMD_COMMIT: begin
                            // Commit the line, or drop an empty or overflowed one
                            if (r_line_open) begin
                                n_line_open = 1'b0;
                                if (r_overflow || (r_pending <= 8'd1)) begin
                                    if (r_pending != 8'd0) begin
                                        n_write_idx = r_length_slot;
                                    end
                                    n_pending  = 8'd0;
                                    n_overflow = 1'b0;
                                    n_dropped  = r_dropped + 32'd1;
                                end else begin
                                    wr_en       = 1'b1;
                                    wr_addr     = r_length_slot;
                                    wr_data     = r_pending - 8'd1;
                                    n_committed = r_committed + r_pending;
                                    n_pending   = 8'd0;
                                    if (n_committed > r_peak) begin
                                        n_peak = n_committed;
                                    end
                                end
                            end
                            do_status = 1'b1;
                        end
                        lrfs_pkg::CMD_UPDATE: begin
                            // Continue a line, start the next one, or report status
                            if (r_sending) begin
                                n_state = S_FRAG;
                            end else if (r_committed != 8'd0) begin
                                rd_en   = 1'b1;
                                rd_addr = r_read_idx;
                                n_state = S_LEN;
                            end else begin
                                do_status = 1'b1;
                            end
                        end
                        default: begin
                            do_status = 1'b1;
                        end
                    endcase
                end
            end
            S_LEN: begin
                // Take the length slot and open the message
                n_cur_len  = rd_data;
                n_pos      = data_idx;
                n_end_idx  = (end_sum >= 9'(RING_DEPTH)) ?
                             IDX_W'(end_sum - 9'(RING_DEPTH)) : IDX_W'(end_sum);
                n_prod     = PROD_W'(frag_x) * PROD_W'(RECIP);
                n_cur_frag = 8'd0;
                n_offset   = '0;
                n_cur_id   = (id_inc == 8'd0) ? 8'd1 : id_inc;
                n_sending  = 1'b1;
                n_state    = S_TOT;
            end
            S_TOT: begin
                n_total = r_prod[SH +: 8];
                n_state = S_FRAG;
            end
            S_FRAG: begin
                // Size the fragment, prime the first read and settle the line
                if (r_offset < X_W'(r_cur_len)) begin
                    n_len = (remain > X_W'(PAYLOAD_BYTES)) ? 6'(PAYLOAD_BYTES) : remain[5:0];
                end else begin
                    n_len = 6'd0;
                end
                n_fi    = r_cur_frag;
                n_fc    = r_total;
                n_cnt   = '0;
                rd_en   = 1'b1;
                rd_addr = r_pos;
                if (!r_accept) begin
                    n_read_idx  = r_end_idx;
                    n_committed = r_committed - (r_cur_len + 8'd1);
                    n_sending   = 1'b0;
                    n_dropped   = r_dropped + 32'd1;
                end else begin
                    n_cur_frag = r_cur_frag + 8'd1;
                    n_offset   = r_offset + X_W'(PAYLOAD_BYTES);
                    if (n_cur_frag >= r_total) begin
                        n_read_idx  = r_end_idx;
                        n_committed = r_committed - (r_cur_len + 8'd1);
                        n_sending   = 1'b0;
                        n_sent      = r_sent + 32'd1;
                    end
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                // Emit one payload byte per free output slot
                if (out_free) begin
                    out_load             = 1'b1;
                    n_out.kind           = lrfs_pkg::KIND_FRAGMENT;
                    n_out.version        = i_cfg_regs.protocol_version;
                    n_out.message_id     = r_cur_id;
                    n_out.fragment_index = r_fi;
                    n_out.fragment_count = r_fc;
                    n_out.payload_length = r_len;
                    n_out.payload_byte   = (6'(r_cnt) < r_len) ? rd_data : 8'd0;
                    n_out.last           = (r_cnt == CNT_W'(PAYLOAD_BYTES - 1));
                    n_out.busy_res       = r_sending || (r_committed != 8'd0);
                    n_out.sent_lines     = r_sent;
                    n_out.dropped_lines  = r_dropped;
                    n_out.ring_peak      = r_peak;
                    if (6'(r_cnt) < r_len) begin
                        n_pos   = ring_next(r_pos);
                        rd_en   = 1'b1;
                        rd_addr = n_pos;
                    end
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(PAYLOAD_BYTES - 1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Build a status result from the state after the operation
        if (do_status) begin
            out_load             = 1'b1;
            n_out.kind           = lrfs_pkg::KIND_STATUS;
            n_out.version        = i_cfg_regs.protocol_version;
            n_out.message_id     = r_cur_id;
            n_out.fragment_index = r_cur_frag;
            n_out.fragment_count = r_total;
            n_out.payload_length = 6'd0;
            n_out.payload_byte   = 8'd0;
            n_out.last           = 1'b1;
            n_out.busy_res       = n_sending || (n_committed != 8'd0);
            n_out.sent_lines     = n_sent;
            n_out.dropped_lines  = n_dropped;
            n_out.ring_peak      = n_peak;
        end

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Hold state, counters and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_write_idx   <= '0;
            r_length_slot <= '0;
            r_pending     <= '0;
            r_line_open   <= 1'b0;
            r_overflow    <= 1'b0;
            r_read_idx    <= '0;
            r_committed   <= '0;
            r_sending     <= 1'b0;
            r_pos         <= '0;
            r_end_idx     <= '0;
            r_cur_len     <= '0;
            r_offset      <= '0;
            r_cur_frag    <= '0;
            r_total       <= '0;
            r_cur_id      <= '0;
            r_sent        <= '0;
            r_dropped     <= '0;
            r_peak        <= '0;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_write_idx   <= n_write_idx;
            r_length_slot <= n_length_slot;
            r_pending     <= n_pending;
            r_line_open   <= n_line_open;
            r_overflow    <= n_overflow;
            r_read_idx    <= n_read_idx;
            r_committed   <= n_committed;
            r_sending     <= n_sending;
            r_pos         <= n_pos;
            r_end_idx     <= n_end_idx;
            r_cur_len     <= n_cur_len;
            r_offset      <= n_offset;
            r_cur_frag    <= n_cur_frag;
            r_total       <= n_total;
            r_cur_id      <= n_cur_id;
            r_sent        <= n_sent;
            r_dropped     <= n_dropped;
            r_peak        <= n_peak;
            r_cnt         <= n_cnt;
            r_out_valid   <= n_out_valid;
        end
        r_out    <= n_out;
        r_prod   <= n_prod;
        r_len    <= n_len;
        r_fi     <= n_fi;
        r_fc     <= n_fc;
        r_accept <= n_accept;
    end

    // Write and read the ring
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            ring_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= ring_mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind == lrfs_pkg::KIND_STATUS)) |-> r_out.last)
        else $error("status result without last");

    a_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sending |-> (r_cur_id != 8'd0))
        else $error("message id zero while sending");

    a_frag_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind == lrfs_pkg::KIND_FRAGMENT)) |->
        (r_out.payload_length <= 6'(PAYLOAD_BYTES)))
        else $error("fragment longer than payload");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind == lrfs_pkg::KIND_FRAGMENT) && r_out.last) |->
        (r_state == S_IDLE))
        else $error("fragment ended while still emitting");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int RING_DEPTH    = 128;
    localparam int PAYLOAD_BYTES = 24;
    localparam int CLK_HALF      = 4;
    localparam int SETTLE_CYCLES = 40;

    // Predicts every result of the sender and checks what comes out of it
    class line_sender_sb;
        logic [7:0]  max_len;
        logic [7:0]  version;
        logic [7:0]  ring [RING_DEPTH];
        int          wr_ptr;
        int          len_slot;
        int          rd_ptr;
        int          data_ptr;
        logic [7:0]  pending;
        logic [7:0]  committed;
        logic [7:0]  cur_len;
        logic [7:0]  cur_frag;
        logic [7:0]  n_frags;
        logic [7:0]  msg_id;
        logic [7:0]  peak;
        bit          line_open;
        bit          line_ovf;
        bit          sending;
        logic [31:0] sent;
        logic [31:0] dropped;
        lrfs_pkg::t_res due_results[$];
        int          errors;
        int          n_requests;
        int          n_results;
        int          n_fragments;

        function new();
            max_len   = lrfs_pkg::LINE_LIMIT_RST;
            version   = lrfs_pkg::PROTOCOL_VERSION_RST;
            wr_ptr    = 0;
            len_slot  = 0;
            rd_ptr    = 0;
            data_ptr  = 0;
            pending   = '0;
            committed = '0;
            cur_len   = '0;
            cur_frag  = '0;
            n_frags   = '0;
            msg_id    = '0;
            peak      = '0;
            line_open = 1'b0;
            line_ovf  = 1'b0;
            sending   = 1'b0;
            sent      = '0;
            dropped   = '0;
            errors    = 0;
            n_requests  = 0;
            n_results   = 0;
            n_fragments = 0;
        endfunction

        task report(input string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void write_register(input logic [7:0] idx, input logic [7:0] data);
            case (idx)
                lrfs_pkg::CFG_LINE_LIMIT:       max_len = data;
                lrfs_pkg::CFG_PROTOCOL_VERSION: version = data;
                default: ;
            endcase
        endfunction

        // Roll back the open line and free whatever it had taken
        function void drop_line();
            if (pending != 0) begin
                wr_ptr  = len_slot;
                pending = '0;
            end
            line_open = 1'b0;
            line_ovf  = 1'b0;
        endfunction

        // Release the line in flight from the ring
        function void finish_line(input bit ok);
            rd_ptr    = (data_ptr + int'(cur_len)) % RING_DEPTH;
            committed = committed - (cur_len + 8'd1);
            sending   = 1'b0;
            if (ok) begin
                sent++;
            end else begin
                dropped++;
            end
        endfunction

        function lrfs_pkg::t_res make_result(input logic k, input logic [7:0] fi,
                                             input logic [7:0] fc, input logic [5:0] len,
                                             input logic [7:0] b, input logic l);
            lrfs_pkg::t_res r;
            r.kind           = k;
            r.version        = version;
            r.message_id     = msg_id;
            r.fragment_index = fi;
            r.fragment_count = fc;
            r.payload_length = len;
            r.payload_byte   = b;
            r.last           = l;
            r.busy_res       = sending || (committed != 0);
            r.sent_lines     = sent;
            r.dropped_lines  = dropped;
            r.ring_peak      = peak;
            return r;
        endfunction

        function void note_request(input lrfs_pkg::t_in_item it);
            logic [7:0] frag [PAYLOAD_BYTES];
            logic [7:0] fi;
            logic [7:0] fc;
            int         offset;
            int         len;
            int         pos;
            n_requests++;
            case (lrfs_pkg::t_cmd'(it.cmd))
                lrfs_pkg::CMD_BEGIN: begin
                    if (line_open) begin
                        drop_line();
                        dropped++;
                    end
                    line_open = 1'b1;
                    line_ovf  = 1'b0;
                    pending   = '0;
                    if (int'(committed) + 1 > RING_DEPTH) begin
                        line_ovf = 1'b1;
                    end else begin
                        len_slot = wr_ptr;
                        wr_ptr   = (wr_ptr + 1) % RING_DEPTH;
                        pending  = 8'd1;
                    end
                end
                lrfs_pkg::CMD_ADD: begin
                    if (line_open && !line_ovf) begin
                        if (pending == 0 || int'(pending) - 1 >= int'(max_len) ||
                            int'(committed) + int'(pending) >= RING_DEPTH) begin
                            line_ovf = 1'b1;
                        end else begin
                            ring[wr_ptr] = it.line_byte;
                            wr_ptr       = (wr_ptr + 1) % RING_DEPTH;
                            pending      = pending + 8'd1;
                        end
                    end
                end
                lrfs_pkg::CMD_COMMIT: begin
                    if (line_open) begin
                        line_open = 1'b0;
                        if (line_ovf || pending <= 1) begin
                            drop_line();
                            dropped++;
                        end else begin
                            ring[len_slot] = pending - 8'd1;
                            committed      = committed + pending;
                            pending        = '0;
                            if (committed > peak) begin
                                peak = committed;
                            end
                        end
                    end
                end
                lrfs_pkg::CMD_UPDATE: begin
                    // start the next committed line when idle
                    if (!sending && committed != 0) begin
                        cur_len  = ring[rd_ptr];
                        data_ptr = (rd_ptr + 1) % RING_DEPTH;
                        n_frags  = 8'((int'(cur_len) + PAYLOAD_BYTES - 1) / PAYLOAD_BYTES);
                        cur_frag = '0;
                        msg_id   = msg_id + 8'd1;
                        if (msg_id == 0) begin
                            msg_id = 8'd1;
                        end
                        sending = 1'b1;
                    end
                    if (sending) begin
                        fi     = cur_frag;
                        fc     = n_frags;
                        offset = int'(cur_frag) * PAYLOAD_BYTES;
                        len    = (offset < int'(cur_len)) ? int'(cur_len) - offset : 0;
                        if (len > PAYLOAD_BYTES) begin
                            len = PAYLOAD_BYTES;
                        end
                        pos = (data_ptr + offset) % RING_DEPTH;
                        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                            if (i < len) begin
                                frag[i] = ring[pos];
                                pos     = (pos + 1) % RING_DEPTH;
                            end else begin
                                frag[i] = '0;
                            end
                        end
                        if (!it.link_accept) begin
                            finish_line(1'b0);
                        end else begin
                            cur_frag = cur_frag + 8'd1;
                            if (cur_frag >= n_frags) begin
                                finish_line(1'b1);
                            end
                        end
                        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                            due_results.push_back(make_result(lrfs_pkg::KIND_FRAGMENT, fi, fc,
                                                              6'(len), frag[i],
                                                              i == PAYLOAD_BYTES - 1));
                        end
                        n_fragments++;
                        return;
                    end
                end
                default: ;
            endcase
            due_results.push_back(make_result(lrfs_pkg::KIND_STATUS, cur_frag, n_frags,
                                              '0, '0, 1'b1));
        endfunction

        task check_field(input string name, input logic [31:0] got, input logic [31:0] want);
            if (got !== want) begin
                report($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                 n_results, name, got, want));
            end
        endtask

        task check_result(input lrfs_pkg::t_res got);
            lrfs_pkg::t_res want;
            if (due_results.size() == 0) begin
                report($sformatf("unexpected result: kind %0d id %0d byte 0x%0h",
                                 got.kind, got.message_id, got.payload_byte));
                return;
            end
            want = due_results.pop_front();
            n_results++;
            check_field("kind", got.kind, want.kind);
            check_field("version", got.version, want.version);
            check_field("message_id", got.message_id, want.message_id);
            check_field("fragment_index", got.fragment_index, want.fragment_index);
            check_field("fragment_count", got.fragment_count, want.fragment_count);
            check_field("payload_length", got.payload_length, want.payload_length);
            check_field("payload_byte", got.payload_byte, want.payload_byte);
            check_field("last", got.last, want.last);
            check_field("busy_res", got.busy_res, want.busy_res);
            check_field("sent_lines", got.sent_lines, want.sent_lines);
            check_field("dropped_lines", got.dropped_lines, want.dropped_lines);
            check_field("ring_peak", got.ring_peak, want.ring_peak);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   quiet;

    line_sender_sb sender;

    lrfs_chan_if #(.t_payload(lrfs_pkg::t_in_item)) item_if ();
    lrfs_chan_if #(.t_payload(lrfs_pkg::t_cfg_req)) cfg_if ();
    lrfs_chan_if #(.t_payload(lrfs_pkg::t_res))     res_if ();

    line_ring_fragmenting_sender #(
        .RING_DEPTH    (RING_DEPTH),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // Clock
    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // Stall the result side in random bursts
    initial begin
        int burst;
        res_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                res_if.ready <= 1'b0;
                burst = $urandom_range(1, 19);
                repeat (burst) @(negedge i_clk);
            end
            res_if.ready <= 1'b1;
        end
    end

    // Check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            sender.check_result(res_if.payload);
        end
    end

    // Hold one request until it is taken; leaves valid high for the caller
    task automatic send_request(input lrfs_pkg::t_cmd c, input logic [7:0] b,
                                input logic acc);
        lrfs_pkg::t_in_item it;
        int                 gap;
        it.cmd         = c;
        it.line_byte   = b;
        it.link_accept = acc;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            item_if.valid <= 1'b0;
            gap = $urandom_range(1, 19);
            repeat (gap) @(negedge i_clk);
        end
        item_if.valid   <= 1'b1;
        item_if.payload <= it;
        do @(posedge i_clk); while (!item_if.ready);
        sender.note_request(it);
        @(negedge i_clk);
    endtask

    task automatic send_line(input int n_bytes, input bit do_commit);
        send_request(lrfs_pkg::CMD_BEGIN, 8'($urandom), 1'($urandom));
        repeat (n_bytes) send_request(lrfs_pkg::CMD_ADD, 8'($urandom), 1'($urandom));
        if (do_commit) begin
            send_request(lrfs_pkg::CMD_COMMIT, 8'($urandom), 1'($urandom));
        end
    endtask

    // Update until every committed line has gone, with the odd refusal
    task automatic send_all_lines();
        while (sender.sending || sender.committed != 0) begin
            send_request(lrfs_pkg::CMD_UPDATE, 8'($urandom), $urandom_range(0, 7) != 0);
        end
    endtask

    // Drop valid and wait until every expected result has arrived
    task automatic wait_drained();
        item_if.valid <= 1'b0;
        while (sender.due_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write both registers back to back
    task automatic set_registers(input logic [7:0] max_len, input logic [7:0] version);
        lrfs_pkg::t_cfg_req wr [2];
        wr[0] = '{index: lrfs_pkg::CFG_LINE_LIMIT, data: max_len};
        wr[1] = '{index: lrfs_pkg::CFG_PROTOCOL_VERSION, data: version};
        foreach (wr[k]) begin
            cfg_if.valid   <= 1'b1;
            cfg_if.payload <= wr[k];
            do @(posedge i_clk); while (!cfg_if.ready);
            sender.write_register(wr[k].index, wr[k].data);
            @(negedge i_clk);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Mostly well-formed lines and updates, with some noise
    task automatic random_traffic(input int budget, input int longest);
        int n_items;
        int n_bytes;
        int pick;
        n_items = 0;
        while (n_items < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                n_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(1, longest)
                                                      : $urandom_range(1, 8);
                send_line(n_bytes, $urandom_range(0, 9) != 0);
                n_items += n_bytes + 2;
            end else if (pick < 85) begin
                send_request(lrfs_pkg::CMD_UPDATE, 8'($urandom), $urandom_range(0, 9) != 0);
                n_items++;
            end else begin
                send_request(lrfs_pkg::t_cmd'(2'($urandom_range(0, 3))), 8'($urandom),
                             1'($urandom));
                n_items++;
            end
            if ($urandom_range(0, 59) == 0) begin
                wait_drained();
            end
        end
    endtask

    // Fill the ring with one long line, overflow the last free slot, fill it exactly,
    // and open a line on the full ring
    task automatic fill_ring();
        int room;
        send_all_lines();
        send_line(RING_DEPTH - 3, 1'b1);
        room = RING_DEPTH - int'(sender.committed) - 1;
        send_line(room + 1, 1'b1);
        send_line(room, 1'b1);
        send_line(1, 1'b1);
        send_all_lines();
    endtask

    // Run limit
    initial begin
        #10_000_000;
        $display("TIMEOUT: results still outstanding");
        $display("Some tests failed");
        $finish;
    end

    initial begin
        sender          = new();
        quiet           = 1'b0;
        i_rst_n         = 1'b0;
        item_if.valid   = 1'b0;
        item_if.payload = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.payload  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: empty update, stray commit and add, short lines, rollbacks,
        // sends, and a refused fragment
        send_request(lrfs_pkg::CMD_UPDATE, 8'h00, 1'b1);
        send_request(lrfs_pkg::CMD_COMMIT, 8'hFF, 1'b0);
        send_request(lrfs_pkg::CMD_ADD, 8'h3C, 1'b0);
        send_request(lrfs_pkg::CMD_BEGIN, 8'h00, 1'b0);
        send_request(lrfs_pkg::CMD_ADD, 8'h00, 1'b0);
        send_request(lrfs_pkg::CMD_ADD, 8'hFF, 1'b1);
        send_request(lrfs_pkg::CMD_COMMIT, 8'h00, 1'b0);
        send_request(lrfs_pkg::CMD_BEGIN, 8'h00, 1'b0);
        send_request(lrfs_pkg::CMD_COMMIT, 8'h00, 1'b0);
        send_request(lrfs_pkg::CMD_BEGIN, 8'h00, 1'b0);
        send_request(lrfs_pkg::CMD_ADD, 8'h81, 1'b0);
        send_request(lrfs_pkg::CMD_BEGIN, 8'h00, 1'b0);
        send_request(lrfs_pkg::CMD_ADD, 8'h7E, 1'b0);
        send_request(lrfs_pkg::CMD_ADD, 8'h55, 1'b0);
        send_request(lrfs_pkg::CMD_COMMIT, 8'h00, 1'b0);
        send_request(lrfs_pkg::CMD_UPDATE, 8'h00, 1'b1);
        send_request(lrfs_pkg::CMD_UPDATE, 8'hFF, 1'b1);
        send_request(lrfs_pkg::CMD_BEGIN, 8'h00, 1'b0);
        send_request(lrfs_pkg::CMD_ADD, 8'h5A, 1'b0);
        send_request(lrfs_pkg::CMD_COMMIT, 8'h00, 1'b0);
        send_request(lrfs_pkg::CMD_UPDATE, 8'h00, 1'b0);
        send_request(lrfs_pkg::CMD_UPDATE, 8'h00, 1'b0);
        wait_drained();

        // One byte per line at most
        set_registers(8'd1, 8'hFF);
        random_traffic(6, 4);
        wait_drained();

        // No bytes allowed: every line is dropped
        set_registers(8'd0, 8'h00);
        random_traffic(5, 4);
        wait_drained();

        // Longest lines and a full ring
        set_registers(8'd255, 8'h5A);
        fill_ring();
        wait_drained();

        // Closing stretch runs without random request gaps or result stalls
        quiet = 1'b1;
        set_registers(8'($urandom_range(2, 10)), 8'($urandom));
        random_traffic(10, 8);
        item_if.valid <= 1'b0;

        for (int w = 0; w < 20000 && sender.due_results.size() != 0; w++) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sender.due_results.size() != 0) begin
            sender.report($sformatf("%0d results never arrived", sender.due_results.size()));
        end

        $display("Covered %0d requests and %0d results, %0d of them in %0d fragments.",
                 sender.n_requests, sender.n_results, sender.n_fragments * PAYLOAD_BYTES,
                 sender.n_fragments);
        $display("Lines sent %0d, lines dropped %0d, ring peak %0d, mismatches %0d.",
                 sender.sent, sender.dropped, sender.peak, sender.errors);
        if (sender.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
